FILE: sv/cksf_pkg.sv
// Shared constants, types and the per-channel kernel for the cross-kernel sharpen filter.
package cksf_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 3;
  localparam int PIX_W     = NUM_CHAN * CHAN_W;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FW_W      = 11;
  localparam int FH_W      = 16;
  localparam int CFG_W     = 16;
  localparam int SUM_W     = CHAN_W + 4;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic             emit;
    logic             drain;
    logic             first;
    logic             last;
    logic             left_edge;
    logic             right_edge;
    logic             hit_ctr;
    logic             hit_rt;
    logic [COL_W-1:0] col;
  } s1_ctl_t;

  // Five times the center minus the four neighbors, clamped to the channel range.
  function automatic chan_t sharpen(input chan_t ctr, input chan_t up, input chan_t lf,
                                    input chan_t rt, input chan_t dn);
    logic [SUM_W-1:0] acc;
    chan_t            res;
    acc = (SUM_W'(ctr) << 2) + SUM_W'(ctr) - SUM_W'(up) - SUM_W'(lf)
          - SUM_W'(rt) - SUM_W'(dn);
    if (acc[SUM_W-1]) begin
      res = '0;
    end else if (|acc[SUM_W-2:CHAN_W]) begin
      res = '1;
    end else begin
      res = acc[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: sv/cksf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cksf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/cross_kernel_sharpen_filter_core.sv
// Top level of the streaming 3x3 cross-kernel RGB sharpen filter with two line buffers.
// A released result passes through the line buffer read registers and then the output register.
// Throughput: one transaction per cycle while the output is not stalled; the line buffer RAM reads and the single
// kernel stage between the read registers and the output register set that rate.
// Results lag the pixel stream by one row; drain transactions release the last row.
// Reset (synchronous, active low) restores 640x480 and clears counters; line buffers are not cleared.
module cross_kernel_sharpen_filter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [cksf_pkg::CHAN_W-1:0]   in_red_in,
  input  logic [cksf_pkg::CHAN_W-1:0]   in_green_in,
  input  logic [cksf_pkg::CHAN_W-1:0]   in_blue_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cksf_pkg::CHAN_W-1:0]   out_red_out,
  output logic [cksf_pkg::CHAN_W-1:0]   out_green_out,
  output logic [cksf_pkg::CHAN_W-1:0]   out_blue_out,
  output logic                          out_frame_end,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [cksf_pkg::CFG_W-1:0]    cfg_wdata
);

  logic [cksf_pkg::FW_W-1:0]  fw_r;
  logic [cksf_pkg::FH_W-1:0]  fh_r;
  logic [cksf_pkg::FW_W-1:0]  w_eff;
  logic [cksf_pkg::FH_W-1:0]  h_eff;
  logic [cksf_pkg::COL_W-1:0] col_r, col_nxt;
  logic [cksf_pkg::FH_W-1:0]  row_r, row_nxt;
  logic [cksf_pkg::FW_W-1:0]  col_inc;
  logic                       col_last;
  logic                       in_accept;
  logic                       is_drain;
  logic                       frame_done;
  logic                       live;

  logic                       s1_valid_r, s1_valid_nxt;
  cksf_pkg::s1_ctl_t          s1_ctl_r, s1_ctl_nxt;
  cksf_pkg::pix_t             s1_pix_r;
  logic                       s1_adv;
  logic                       wr_en;

  cksf_pkg::pix_t             ram_ctr_rdata, ram_rt_rdata, ram_abv_rdata;
  cksf_pkg::pix_t             last_in_r, last_ctr_r;
  cksf_pkg::pix_t             ctr_pix, abv_pix, rt_pix, incoming;
  cksf_pkg::pix_t             res_pix;

  logic                       out_valid_r, out_valid_nxt;
  cksf_pkg::pix_t             out_pix_r;
  logic                       out_frame_end_r;

  // Frame geometry with out-of-range settings folded to legal values.
  always_comb begin
    w_eff = fw_r;
    if (fw_r == '0) begin
      w_eff = cksf_pkg::FW_W'(1);
    end else if (fw_r > cksf_pkg::FW_W'(cksf_pkg::MAX_WIDTH)) begin
      w_eff = cksf_pkg::FW_W'(cksf_pkg::MAX_WIDTH);
    end
    h_eff = (fh_r == '0) ? cksf_pkg::FH_W'(1) : fh_r;
  end

  assign col_inc    = {1'b0, col_r} + cksf_pkg::FW_W'(1);
  assign col_last   = col_inc >= w_eff;
  assign is_drain   = (in_operation == cksf_pkg::OP_DRAIN);
  assign frame_done = row_r >= h_eff;
  assign live       = is_drain ? frame_done : !frame_done;

  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;
  assign wr_en     = s1_valid_r && s1_adv;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_accept && live) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = is_drain ? '0 : row_r + cksf_pkg::FH_W'(1);
      end else begin
        col_nxt = col_inc[cksf_pkg::COL_W-1:0];
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_accept && live;
    end
    s1_ctl_nxt.emit       = is_drain || (row_r != '0);
    s1_ctl_nxt.drain      = is_drain;
    s1_ctl_nxt.first      = is_drain ? (h_eff == cksf_pkg::FH_W'(1))
                                     : (row_r == cksf_pkg::FH_W'(1));
    s1_ctl_nxt.last       = is_drain && col_last;
    s1_ctl_nxt.left_edge  = (col_r == '0);
    s1_ctl_nxt.right_edge = col_last;
    s1_ctl_nxt.hit_ctr    = wr_en && (s1_ctl_r.col == col_r);
    s1_ctl_nxt.hit_rt     = wr_en && (s1_ctl_r.col == col_inc[cksf_pkg::COL_W-1:0]);
    s1_ctl_nxt.col        = col_r;
  end

  cksf_ram #(.WIDTH(cksf_pkg::PIX_W), .DEPTH(cksf_pkg::MAX_WIDTH)) u_ctr_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_ctl_r.col),
    .wdata (incoming),
    .re    (in_accept),
    .raddr (col_r),
    .rdata (ram_ctr_rdata)
  );

  cksf_ram #(.WIDTH(cksf_pkg::PIX_W), .DEPTH(cksf_pkg::MAX_WIDTH)) u_rt_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_ctl_r.col),
    .wdata (incoming),
    .re    (in_accept),
    .raddr (col_inc[cksf_pkg::COL_W-1:0]),
    .rdata (ram_rt_rdata)
  );

  cksf_ram #(.WIDTH(cksf_pkg::PIX_W), .DEPTH(cksf_pkg::MAX_WIDTH)) u_abv_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_ctl_r.col),
    .wdata (ctr_pix),
    .re    (in_accept),
    .raddr (col_r),
    .rdata (ram_abv_rdata)
  );

  // A read that coincides with the write of the same column takes the written data.
  always_comb begin
    ctr_pix  = s1_ctl_r.hit_ctr ? last_in_r  : ram_ctr_rdata;
    abv_pix  = s1_ctl_r.hit_ctr ? last_ctr_r : ram_abv_rdata;
    rt_pix   = s1_ctl_r.hit_rt  ? last_in_r  : ram_rt_rdata;
    incoming = s1_ctl_r.drain   ? ctr_pix    : s1_pix_r;
    for (int k = 0; k < cksf_pkg::NUM_CHAN; k++) begin
      res_pix[k] = cksf_pkg::sharpen(
        ctr_pix[k],
        s1_ctl_r.first      ? ctr_pix[k] : abv_pix[k],
        s1_ctl_r.left_edge  ? ctr_pix[k] : last_ctr_r[k],
        s1_ctl_r.right_edge ? ctr_pix[k] : rt_pix[k],
        incoming[k]);
    end
  end

  assign out_valid_nxt = s1_adv ? (s1_valid_r && s1_ctl_r.emit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= cksf_pkg::FW_W'(640);
      fh_r        <= cksf_pkg::FH_W'(480);
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cksf_pkg::CFG_FRAME_WIDTH:  fw_r <= cfg_wdata[cksf_pkg::FW_W-1:0];
          cksf_pkg::CFG_FRAME_HEIGHT: fh_r <= cfg_wdata[cksf_pkg::FH_W-1:0];
          default: ;
        endcase
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_ctl_r <= s1_ctl_nxt;
      s1_pix_r <= {in_blue_in, in_green_in, in_red_in};
    end
    if (wr_en) begin
      last_in_r  <= incoming;
      last_ctr_r <= ctr_pix;
    end
    if (s1_adv) begin
      out_pix_r       <= res_pix;
      out_frame_end_r <= s1_ctl_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_pix_r[0];
  assign out_green_out = out_pix_r[1];
  assign out_blue_out  = out_pix_r[2];
  assign out_frame_end = out_frame_end_r;

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < w_eff)
    else $error("column counter outside the frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= h_eff)
    else $error("row counter beyond the frame height");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_ctl_r.emit))
    else $error("result appeared without an emitting item in the kernel stage");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && is_drain && frame_done && col_last) |=> (col_r == '0 && row_r == '0))
    else $error("counters did not restart after the final drain of the frame");

endmodule

FILE: test/cross_kernel_sharpen_filter_core_test.sv
// Self-checking testbench for the cross-kernel sharpen filter core with its own line-buffer predictor.
module cross_kernel_sharpen_filter_core_test;

  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    cksf_pkg::op_t  op;
    cksf_pkg::pix_t px;
  } pixel_item_t;

  typedef struct {
    cksf_pkg::pix_t px;
    logic           frame_end;
  } sharpened_t;

  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_BUSY
  } rx_mode_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_operation = 1'b0;
  logic [cksf_pkg::CHAN_W-1:0] in_red_in = '0;
  logic [cksf_pkg::CHAN_W-1:0] in_green_in = '0;
  logic [cksf_pkg::CHAN_W-1:0] in_blue_in = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b1;
  logic [cksf_pkg::CHAN_W-1:0] out_red_out;
  logic [cksf_pkg::CHAN_W-1:0] out_green_out;
  logic [cksf_pkg::CHAN_W-1:0] out_blue_out;
  logic                        out_frame_end;
  logic                        cfg_we = 1'b0;
  logic                        cfg_index = 1'b0;
  logic [cksf_pkg::CFG_W-1:0]  cfg_wdata = '0;

  pixel_item_t pixel_feed[$];
  sharpened_t  sharpened_q[$];

  cksf_pkg::pix_t            above_row[cksf_pkg::MAX_WIDTH];
  cksf_pkg::pix_t            center_row[cksf_pkg::MAX_WIDTH];
  int unsigned               col_pos = 0;
  int unsigned               row_pos = 0;
  logic [cksf_pkg::FW_W-1:0] width_reg = cksf_pkg::FW_W'(640);
  logic [cksf_pkg::FH_W-1:0] height_reg = cksf_pkg::FH_W'(480);

  logic        in_taken = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned ready_tick = 0;
  rx_mode_t    stall_mode = RX_STEADY;

  cross_kernel_sharpen_filter_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Updates the line buffers and counters for one transaction and records the pixel it releases.
  task automatic sharpen_and_advance(input cksf_pkg::op_t op, input cksf_pkg::pix_t px);
    int unsigned    w;
    int unsigned    h;
    int unsigned    c;
    logic           drain;
    logic           emit;
    logic           first_out;
    logic           last_out;
    cksf_pkg::pix_t incoming;
    cksf_pkg::pix_t ctr;
    cksf_pkg::pix_t up;
    cksf_pkg::pix_t lf;
    cksf_pkg::pix_t rt;
    sharpened_t     res;
    int             v;
    w = (width_reg == 0) ? 1 : ((width_reg > cksf_pkg::MAX_WIDTH) ? cksf_pkg::MAX_WIDTH
                                                                   : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    c = col_pos;
    drain = (op == cksf_pkg::OP_DRAIN);
    last_out = 1'b0;
    if (drain && row_pos < h) return;
    if (!drain && row_pos >= h) return;
    if (drain) begin
      incoming = center_row[c];
      emit = 1'b1;
      first_out = (h == 1);
      last_out = (c + 1 >= w);
    end else begin
      incoming = px;
      emit = (row_pos >= 1);
      first_out = (row_pos == 1);
    end
    if (emit) begin
      ctr = center_row[c];
      up = first_out ? ctr : above_row[c];
      lf = (c > 0) ? above_row[c - 1] : ctr;
      rt = (c + 1 < w) ? center_row[c + 1] : ctr;
      for (int k = 0; k < cksf_pkg::NUM_CHAN; k++) begin
        v = 5 * int'(ctr[k]) - int'(up[k]) - int'(lf[k]) - int'(rt[k]) - int'(incoming[k]);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        res.px[k] = v[cksf_pkg::CHAN_W-1:0];
      end
      res.frame_end = last_out;
      sharpened_q.push_back(res);
    end
    above_row[c] = center_row[c];
    center_row[c] = incoming;
    if (drain) begin
      if (last_out) begin
        col_pos = 0;
        row_pos = 0;
      end else begin
        col_pos = c + 1;
      end
    end else if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  function automatic cksf_pkg::chan_t pick_level(input int unsigned style);
    case (style)
      0: return cksf_pkg::chan_t'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return cksf_pkg::chan_t'($urandom_range(120, 135));
    endcase
  endfunction

  task automatic queue_item(input cksf_pkg::op_t op, input cksf_pkg::chan_t r,
                            input cksf_pkg::chan_t g, input cksf_pkg::chan_t b);
    pixel_item_t it;
    it.op = op;
    it.px = {b, g, r};
    pixel_feed.push_back(it);
  endtask

  // Waits until every queued transaction is accepted and every expected pixel has arrived.
  task automatic settle();
    bit busy;
    busy = 1'b1;
    while (busy) begin
      @(posedge clk);
      busy = (pixel_feed.size() != 0) || in_valid;
      @(negedge clk);
      busy = busy || (sharpened_q.size() != 0);
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(input cksf_pkg::cfg_idx_t idx,
                                input logic [cksf_pkg::CFG_W-1:0] value);
    settle();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    if (idx == cksf_pkg::CFG_FRAME_WIDTH) begin
      width_reg = value[cksf_pkg::FW_W-1:0];
    end else begin
      height_reg = value;
    end
    col_pos = 0;
    row_pos = 0;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  always @(negedge clk) begin
    pixel_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pixel_feed.size() != 0) begin
        nxt = pixel_feed.pop_front();
        in_valid <= 1'b1;
        in_operation <= nxt.op;
        in_red_in <= nxt.px[0];
        in_green_in <= nxt.px[1];
        in_blue_in <= nxt.px[2];
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 15)
                                                  : $urandom_range(0, 4);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
    end else begin
      if (ready_tick == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        ready_tick = $urandom_range(20, 120);
      end else begin
        ready_tick = ready_tick - 1;
      end
      case (stall_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= (ready_tick % 4 == 0);
        default:   out_ready <= ($urandom_range(0, 5) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    sharpened_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (sharpened_q.size() == 0) begin
          $error("output transaction with no pixel expected");
          mismatches++;
        end else begin
          want = sharpened_q.pop_front();
          if (out_red_out !== want.px[0]) begin
            $error("red_out: expected %0d, actual %0d", want.px[0], out_red_out);
            mismatches++;
          end
          if (out_green_out !== want.px[1]) begin
            $error("green_out: expected %0d, actual %0d", want.px[1], out_green_out);
            mismatches++;
          end
          if (out_blue_out !== want.px[2]) begin
            $error("blue_out: expected %0d, actual %0d", want.px[2], out_blue_out);
            mismatches++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", want.frame_end, out_frame_end);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        sharpen_and_advance(cksf_pkg::op_t'(in_operation),
                            {in_blue_in, in_green_in, in_red_in});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL cross_kernel_sharpen_filter_core");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned style;
    int unsigned pick;
    int unsigned nframes;
    int unsigned cut;
    int unsigned extra_px;
    int unsigned total_px;
    int unsigned gen_w;
    int unsigned gen_h;
    int unsigned new_w;
    int unsigned new_h;
    int unsigned frame_items;
    int          early_at;
    bit          must_restart;
    bit          broken;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A few pixels at the reset size of 640 by 480, cut short by the first register write.
    for (i = 0; i < 8; i++) begin
      queue_item(cksf_pkg::OP_PIXEL, cksf_pkg::chan_t'($urandom), cksf_pkg::chan_t'($urandom),
                 cksf_pkg::chan_t'($urandom));
    end

    // A 3 by 3 frame with clamping values, an early drain and a surplus pixel.
    write_register(cksf_pkg::CFG_FRAME_WIDTH, 16'd3);
    write_register(cksf_pkg::CFG_FRAME_HEIGHT, 16'd3);
    for (i = 0; i < 9; i++) begin
      if (i == 4) queue_item(cksf_pkg::OP_DRAIN, 8'd0, 8'd0, 8'd0);
      queue_item(cksf_pkg::OP_PIXEL, (i % 2) ? 8'd255 : 8'd0, (i % 2) ? 8'd0 : 8'd255,
                 (i == 4) ? 8'd255 : cksf_pkg::chan_t'(8 * i));
    end
    queue_item(cksf_pkg::OP_PIXEL, 8'd255, 8'd255, 8'd255);
    repeat (3) queue_item(cksf_pkg::OP_DRAIN, 8'd255, 8'd0, 8'd255);

    // A zero width acts as a single column.
    write_register(cksf_pkg::CFG_FRAME_WIDTH, 16'd0);
    write_register(cksf_pkg::CFG_FRAME_HEIGHT, 16'd1);
    queue_item(cksf_pkg::OP_PIXEL, 8'd255, 8'd0, 8'd128);
    queue_item(cksf_pkg::OP_DRAIN, 8'd0, 8'd0, 8'd0);

    // An oversized width with a zero height, cut short by the next register write.
    write_register(cksf_pkg::CFG_FRAME_WIDTH, 16'd2047);
    write_register(cksf_pkg::CFG_FRAME_HEIGHT, 16'd0);
    for (i = 0; i < 16; i++) begin
      queue_item(cksf_pkg::OP_PIXEL, cksf_pkg::chan_t'($urandom), cksf_pkg::chan_t'($urandom),
                 cksf_pkg::chan_t'($urandom));
    end

    // Tallest frame in a single column, cut short by the next register write.
    write_register(cksf_pkg::CFG_FRAME_WIDTH, 16'd1);
    write_register(cksf_pkg::CFG_FRAME_HEIGHT, 16'd65535);
    for (i = 0; i < 12; i++) begin
      queue_item(cksf_pkg::OP_PIXEL, cksf_pkg::chan_t'($urandom), cksf_pkg::chan_t'($urandom),
                 cksf_pkg::chan_t'($urandom));
    end

    frame_items = 0;
    must_restart = 1'b1;
    gen_w = 1;
    gen_h = 1;
    while (frame_items < 590) begin
      new_w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
      new_h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      pick = must_restart ? 0 : $urandom_range(0, 3);
      if (pick == 0 || pick == 1) begin
        write_register(cksf_pkg::CFG_FRAME_WIDTH, cksf_pkg::CFG_W'(new_w));
        gen_w = (new_w == 0) ? 1 : new_w;
      end
      if (pick == 0 || pick == 2) begin
        write_register(cksf_pkg::CFG_FRAME_HEIGHT, cksf_pkg::CFG_W'(new_h));
        gen_h = (new_h == 0) ? 1 : new_h;
      end
      must_restart = 1'b0;
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        style = $urandom_range(0, 2);
        total_px = gen_w * gen_h;
        broken = ($urandom_range(0, 9) == 0);
        cut = broken ? $urandom_range(1, total_px + gen_w - 1) : total_px + gen_w;
        early_at = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, total_px - 1)) : -1;
        extra_px = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
        for (i = 0; i < cut; i++) begin
          if (int'(i) == early_at) queue_item(cksf_pkg::OP_DRAIN, 8'd0, 8'd0, 8'd0);
          if (i == total_px) begin
            repeat (extra_px) begin
              queue_item(cksf_pkg::OP_PIXEL, pick_level(style), pick_level(style),
                         pick_level(style));
            end
          end
          if (i < total_px) begin
            queue_item(cksf_pkg::OP_PIXEL, pick_level(style), pick_level(style),
                       pick_level(style));
          end else begin
            queue_item(cksf_pkg::OP_DRAIN, cksf_pkg::chan_t'($urandom),
                       cksf_pkg::chan_t'($urandom), cksf_pkg::chan_t'($urandom));
          end
          frame_items++;
        end
        if (broken) begin
          must_restart = 1'b1;
          break;
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS cross_kernel_sharpen_filter_core");
    end else begin
      $display("FAIL cross_kernel_sharpen_filter_core");
    end
    $finish;
  end

endmodule
